### src/npl_pkg.sv
// ----------------------------------------------------------------------------
// npl_pkg - shared definitions for the nearest point lookup
// Field widths, opcode and status codes, and the structs that travel
// along the chain of compare cells.
// ----------------------------------------------------------------------------
package npl_pkg;

	localparam int NPL_TABLE_DEPTH = 1024;

	// compare cells in the chain; entry i lives in cell i mod NUM_CELLS
	localparam int NUM_CELLS = 4;
	localparam int CELL_BITS = 2;

	localparam int COORD_W   = 24;
	localparam int VALUE_W   = 16;
	localparam int ENTRY_W   = 2 * COORD_W + VALUE_W;
	localparam int SQ_W      = 2 * COORD_W;
	localparam int DIST_W    = 50;
	localparam int OUT_IDX_W = 10;
	localparam int OP_W      = 2;
	localparam int STAT_W    = 3;
	localparam int IN_DATA_W = 64;
	localparam int OUT_DATA_W = 80;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_QUERY = 2'd1,
		OP_CLEAR = 2'd2
	} opcode_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_LOADED   = 3'd0,
		STAT_FULL     = 3'd1,
		STAT_ANSWERED = 3'd2,
		STAT_EMPTY    = 3'd3,
		STAT_CLEARED  = 3'd4
	} status_t;

	// scan request handed from cell to cell
	typedef struct packed {
		logic valid;
		logic last;
	} npl_req_t;

	// running best of one row, handed from cell to cell
	typedef struct packed {
		logic                valid;
		logic                last;
		logic                have;
		logic [DIST_W-1:0]   dsq;
		logic [VALUE_W-1:0]  val;
	} npl_best_t;

	// table write, broadcast to all cells
	typedef struct packed {
		logic                 en;
		logic [CELL_BITS-1:0] sel;
		logic [ENTRY_W-1:0]   data;
	} npl_wr_t;

	// row address width of one cell bank
	function automatic int row_w(input int depth);
		int rows;
		rows = (depth + NUM_CELLS - 1) / NUM_CELLS;
		return (rows > 1) ? $clog2(rows) : 1;
	endfunction

endpackage

### src/npl_cell.sv
// ----------------------------------------------------------------------------
// npl_cell - one compare cell of the lookup chain
// Holds one bank of the point table. Per row request it reads its entry,
// computes the squared distance to the query and merges it with the best
// handed in from the left neighbor. Request and best both hop one cell per
// cycle, so they stay aligned along the chain.
// ----------------------------------------------------------------------------
module npl_cell
	import npl_pkg::*;
#(
	parameter int TABLE_DEPTH = NPL_TABLE_DEPTH,
	parameter int CELL_ID     = 0
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  npl_wr_t                                 wr,
	input  logic [row_w(TABLE_DEPTH)-1:0]           wr_row,
	input  logic [COORD_W-1:0]                      qx,
	input  logic [COORD_W-1:0]                      qy,
	input  logic [row_w(TABLE_DEPTH)+CELL_BITS:0]   count,
	input  npl_req_t                                req_in,
	input  logic [row_w(TABLE_DEPTH)-1:0]           row_in,
	output npl_req_t                                req_out,
	output logic [row_w(TABLE_DEPTH)-1:0]           row_out,
	input  npl_best_t                               best_in,
	input  logic [row_w(TABLE_DEPTH)+CELL_BITS-1:0] idx_in,
	output npl_best_t                               best_out,
	output logic [row_w(TABLE_DEPTH)+CELL_BITS-1:0] idx_out
);

	localparam int ROWS  = (TABLE_DEPTH + NUM_CELLS - 1) / NUM_CELLS;
	localparam int ROW_W = row_w(TABLE_DEPTH);
	localparam int IXW   = ROW_W + CELL_BITS;
	localparam int CW    = IXW + 1;

	logic [ENTRY_W-1:0] mem [ROWS];
	logic [ENTRY_W-1:0] rd_s1;

	npl_req_t            req_q;
	logic [ROW_W-1:0]    row_q;

	logic [IXW-1:0]      ix_in;
	logic                ok_in;

	logic                v_s1, last_s1, ok_s1;
	logic [IXW-1:0]      ix_s1;
	logic                v_s2, last_s2, ok_s2;
	logic [IXW-1:0]      ix_s2;
	logic [COORD_W-1:0]  dx_s2, dy_s2;
	logic [VALUE_W-1:0]  val_s2;
	logic                v_s3, last_s3, ok_s3;
	logic [IXW-1:0]      ix_s3;
	logic [SQ_W-1:0]     sqx_s3, sqy_s3;
	logic [VALUE_W-1:0]  val_s3;
	logic                v_s4, last_s4, ok_s4;
	logic [IXW-1:0]      ix_s4;
	logic [DIST_W-1:0]   dist_s4;
	logic [VALUE_W-1:0]  val_s4;

	logic [COORD_W:0]    diff_x, diff_y;
	logic [COORD_W-1:0]  abs_x, abs_y;
	logic                take_own;

	logic                best_valid_q, best_last_q, best_have_q;
	logic [DIST_W-1:0]   best_dist_q;
	logic [VALUE_W-1:0]  best_val_q;
	logic [IXW-1:0]      idx_q;

	assign ix_in = {row_in, CELL_BITS'(CELL_ID)};
	assign ok_in = req_in.valid && (CW'(ix_in) < count);

	// table bank
	always_ff @(posedge clk) begin
		if (wr.en && (wr.sel == CELL_BITS'(CELL_ID))) begin
			mem[wr_row] <= wr.data;
		end
		rd_s1 <= mem[row_in];
	end

	// sign-extended difference, then magnitude; fits COORD_W bits
	assign diff_x = {qx[COORD_W-1], qx} - {rd_s1[COORD_W-1], rd_s1[COORD_W-1:0]};
	assign diff_y = {qy[COORD_W-1], qy}
		- {rd_s1[2*COORD_W-1], rd_s1[2*COORD_W-1:COORD_W]};
	assign abs_x  = diff_x[COORD_W] ? COORD_W'(~diff_x + 1'b1) : diff_x[COORD_W-1:0];
	assign abs_y  = diff_y[COORD_W] ? COORD_W'(~diff_y + 1'b1) : diff_y[COORD_W-1:0];

	// strict less-than: the lower index from the left keeps ties
	assign take_own = ok_s4 && (!best_in.have || (dist_s4 < best_in.dsq));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q        <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			v_s4         <= 1'b0;
			best_valid_q <= 1'b0;
			best_last_q  <= 1'b0;
		end else begin
			req_q        <= req_in;
			v_s1         <= req_in.valid;
			v_s2         <= v_s1;
			v_s3         <= v_s2;
			v_s4         <= v_s3;
			best_valid_q <= v_s4;
			best_last_q  <= last_s4;
		end
	end

	always_ff @(posedge clk) begin
		row_q   <= row_in;

		last_s1 <= req_in.last;
		ok_s1   <= ok_in;
		ix_s1   <= ix_in;

		last_s2 <= last_s1;
		ok_s2   <= ok_s1;
		ix_s2   <= ix_s1;
		dx_s2   <= abs_x;
		dy_s2   <= abs_y;
		val_s2  <= rd_s1[ENTRY_W-1:2*COORD_W];

		last_s3 <= last_s2;
		ok_s3   <= ok_s2;
		ix_s3   <= ix_s2;
		sqx_s3  <= dx_s2 * dx_s2;
		sqy_s3  <= dy_s2 * dy_s2;
		val_s3  <= val_s2;

		last_s4 <= last_s3;
		ok_s4   <= ok_s3;
		ix_s4   <= ix_s3;
		dist_s4 <= DIST_W'(sqx_s3) + DIST_W'(sqy_s3);
		val_s4  <= val_s3;

		best_have_q <= best_in.have | ok_s4;
		if (take_own) begin
			best_dist_q <= dist_s4;
			best_val_q  <= val_s4;
			idx_q       <= ix_s4;
		end else begin
			best_dist_q <= best_in.dsq;
			best_val_q  <= best_in.val;
			idx_q       <= idx_in;
		end
	end

	assign req_out  = req_q;
	assign row_out  = row_q;
	assign best_out = '{valid: best_valid_q, last: best_last_q, have: best_have_q,
		dsq: best_dist_q, val: best_val_q};
	assign idx_out  = idx_q;

endmodule

### src/nearest_point_lookup.sv
// ----------------------------------------------------------------------------
// nearest_point_lookup - brute-force 2-D nearest point table
// Loads points with values, answers nearest-point queries by squared
// Euclidean distance (lowest index wins ties), and clears the table.
//
//   channel   dir  tdata / tuser                                  per txn
//   s_axis    in   x, y, value / opcode                          one command
//   m_axis    out  value, index, dist_sq / status                one result
//
// Load and clear: the result is registered in the cycle after accept.
// Query: the table is split over four compare cells, each reading one entry
// of its bank per cycle during the scan; the rows then pass the pipeline of
// the cell chain before the result is registered.
// One command at a time; s_axis_tready is low while a query scans and while
// an untaken result blocks the output register.
// Reset empties the table; no clearing pass is needed.
// ----------------------------------------------------------------------------
module nearest_point_lookup
	import npl_pkg::*;
#(
	parameter int TABLE_DEPTH = NPL_TABLE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // coord_x, coord_y, point_value
	input  logic [OP_W-1:0]       s_axis_tuser,  // opcode
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // nearest_value, nearest_index,
	                                              // nearest_dist_sq, zero pad
	output logic [STAT_W-1:0]     m_axis_tuser   // status
);

	localparam int ROWS  = (TABLE_DEPTH + NUM_CELLS - 1) / NUM_CELLS;
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int IXW   = ROW_W + CELL_BITS;
	localparam int CW    = IXW + 1;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_WAIT = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       count_q;
	logic [COORD_W-1:0]  qx_q, qy_q;
	logic [ROW_W-1:0]    scan_row_q, last_row_q;
	logic [CW-1:0]       count_m1;

	logic                acc_have_q;
	logic [DIST_W-1:0]   acc_dist_q;
	logic [VALUE_W-1:0]  acc_val_q;
	logic [IXW-1:0]      acc_idx_q;

	logic                m_valid_q;
	status_t             m_stat_q;
	logic [VALUE_W-1:0]  m_val_q;
	logic [OUT_IDX_W-1:0] m_idx_q;
	logic [DIST_W-1:0]   m_dist_q;

	logic                accept, out_free, full, result_set;
	opcode_t             op;
	logic [COORD_W-1:0]  in_x, in_y;
	logic [VALUE_W-1:0]  in_val;

	npl_wr_t             wr;
	logic [ROW_W-1:0]    wr_row;

	npl_req_t            req_c  [NUM_CELLS+1];
	logic [ROW_W-1:0]    row_c  [NUM_CELLS+1];
	npl_best_t           best_c [NUM_CELLS+1];
	logic [IXW-1:0]      idx_c  [NUM_CELLS+1];

	npl_best_t           tail;
	logic                tail_take;

	assign op     = opcode_t'(s_axis_tuser);
	assign in_x   = s_axis_tdata[COORD_W-1:0];
	assign in_y   = s_axis_tdata[2*COORD_W-1:COORD_W];
	assign in_val = s_axis_tdata[ENTRY_W-1:2*COORD_W];

	assign out_free      = !m_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE) && out_free;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign full          = (count_q >= CW'(TABLE_DEPTH));
	assign count_m1      = count_q - 1'b1;

	// a result is loaded by every command except a query that has to scan
	assign result_set = (accept && !((op == OP_QUERY) && (count_q != '0)))
		|| ((state_q == S_DONE) && out_free);

	assign wr = '{en: accept && (op == OP_LOAD) && !full,
		sel: count_q[CELL_BITS-1:0], data: {in_val, in_y, in_x}};
	assign wr_row  = count_q[CELL_BITS +: ROW_W];

	// head of the chain
	assign req_c[0] = '{valid: (state_q == S_SCAN), last: (scan_row_q == last_row_q)};
	assign row_c[0]       = scan_row_q;
	assign best_c[0]      = '0;
	assign idx_c[0]       = '0;

	for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
		npl_cell #(
			.TABLE_DEPTH(TABLE_DEPTH),
			.CELL_ID    (k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr      (wr),
			.wr_row  (wr_row),
			.qx      (qx_q),
			.qy      (qy_q),
			.count   (count_q),
			.req_in  (req_c[k]),
			.row_in  (row_c[k]),
			.req_out (req_c[k+1]),
			.row_out (row_c[k+1]),
			.best_in (best_c[k]),
			.idx_in  (idx_c[k]),
			.best_out(best_c[k+1]),
			.idx_out (idx_c[k+1])
		);
	end

	// rows come out of the chain in index order; strict compare keeps ties
	assign tail      = best_c[NUM_CELLS];
	assign tail_take = tail.valid && tail.have && (!acc_have_q || (tail.dsq < acc_dist_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			m_valid_q  <= 1'b0;
			acc_have_q <= 1'b0;
		end else begin
			if (result_set) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			if (tail_take) begin
				acc_have_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (op)
							OP_LOAD: begin
								if (!full) begin
									count_q <= count_q + 1'b1;
								end
							end
							OP_QUERY: begin
								acc_have_q <= 1'b0;
								if (count_q != '0) begin
									state_q <= S_SCAN;
								end
							end
							default: begin
								// clear; the unused code decodes the same way
								count_q   <= '0;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (req_c[0].last) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (tail.valid && tail.last) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (tail_take) begin
			acc_dist_q <= tail.dsq;
			acc_val_q  <= tail.val;
			acc_idx_q  <= idx_c[NUM_CELLS];
		end
		if (state_q == S_SCAN) begin
			scan_row_q <= scan_row_q + 1'b1;
		end
		if (accept) begin
			qx_q       <= in_x;
			qy_q       <= in_y;
			scan_row_q <= '0;
			last_row_q <= count_m1[CELL_BITS +: ROW_W];
			m_val_q    <= '0;
			m_idx_q    <= '0;
			m_dist_q   <= '0;
			unique case (op)
				OP_LOAD:  m_stat_q <= full ? STAT_FULL : STAT_LOADED;
				OP_QUERY: m_stat_q <= STAT_EMPTY;
				default:  m_stat_q <= STAT_CLEARED;
			endcase
		end
		if ((state_q == S_DONE) && out_free) begin
			m_stat_q <= STAT_ANSWERED;
			m_val_q  <= acc_val_q;
			m_idx_q  <= OUT_IDX_W'(acc_idx_q);
			m_dist_q <= acc_dist_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_stat_q;
	assign m_axis_tdata  = {(OUT_DATA_W - VALUE_W - OUT_IDX_W - DIST_W)'(0),
		m_dist_q, m_idx_q, m_val_q};

endmodule

### src/npl_checker.sv
// ----------------------------------------------------------------------------
// npl_checker - port-level checks for the nearest point lookup
// Watches both stream channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
module npl_checker
	import npl_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic [IN_DATA_W-1:0]  s_axis_tdata,
	input logic [OP_W-1:0]       s_axis_tuser,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic [STAT_W-1:0]     m_axis_tuser
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("stalled result changed");

	// load and clear answer in the very next cycle
	a_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser != OP_QUERY) |=> m_axis_tvalid)
		else $error("load or clear result late");

	// only an answered query carries payload
	a_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != STAT_ANSWERED) |-> (m_axis_tdata == '0))
		else $error("nonzero payload on non-answer result");

	// no new transaction while a result is stuck
	a_no_accept_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("command taken while result blocked");

endmodule

bind nearest_point_lookup npl_checker u_npl_checker (.*);
